// ===== hw/rtl/kmsh_pkg.sv =====
package kmsh_pkg;

   localparam int SHINGLE_LEN = 8;
   localparam int BYTE_W      = 8;
   localparam int HASH_W      = 32;
   localparam int WINDOW_W    = SHINGLE_LEN * BYTE_W;
   localparam int FILL_W      = $clog2(SHINGLE_LEN + 1);

   localparam logic [HASH_W-1:0] CRC_POLY_REFL = 32'hEDB8_8320;
   localparam logic [HASH_W-1:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;

   typedef logic [SHINGLE_LEN-1:0][BYTE_W-1:0] window_type;
   typedef logic [WINDOW_W-1:0][HASH_W-1:0]    crc_columns_type;
   typedef logic [FILL_W-1:0]                  fill_type;

   // One reflected CRC byte update, eight shift steps.
   function automatic logic [HASH_W-1:0] crc_byte_step(
      input logic [HASH_W-1:0] crc_in,
      input logic [BYTE_W-1:0] data_in
   );
      logic [HASH_W-1:0] crc;
      crc = crc_in ^ {{(HASH_W-BYTE_W){1'b0}}, data_in};
      for (int b = 0; b < BYTE_W; b++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY_REFL;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   // The CRC is linear in the data bits. Each column is the contribution of one
   // window bit with a zero initial value; index is byte * 8 + bit, byte 0 oldest.
   function automatic crc_columns_type build_crc_columns();
      crc_columns_type   cols;
      logic [HASH_W-1:0] crc;
      logic [BYTE_W-1:0] data;
      for (int p = 0; p < SHINGLE_LEN; p++) begin
         for (int j = 0; j < BYTE_W; j++) begin
            crc = '0;
            for (int i = 0; i < SHINGLE_LEN; i++) begin
               data = (i == p) ? BYTE_W'(1) << j : '0;
               crc  = crc_byte_step(crc, data);
            end
            cols[p*BYTE_W + j] = crc;
         end
      end
      return cols;
   endfunction

   // Hash of an all-zero window, including the initial value and final inversion.
   function automatic logic [HASH_W-1:0] build_crc_base();
      logic [HASH_W-1:0] crc;
      crc = CRC_ALL_ONES;
      for (int i = 0; i < SHINGLE_LEN; i++) begin
         crc = crc_byte_step(crc, '0);
      end
      return crc ^ CRC_ALL_ONES;
   endfunction

endpackage

// ===== hw/rtl/kmsh_req_if.sv =====
interface kmsh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] seq_byte;
   logic       seq_start;

   modport source (output valid, output seq_byte, output seq_start, input ready);
   modport sink   (input valid, input seq_byte, input seq_start, output ready);
endinterface

// ===== hw/rtl/kmsh_rsp_if.sv =====
interface kmsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] shingle_hash;

   modport source (output valid, output shingle_hash, input ready);
   modport sink   (input valid, input shingle_hash, output ready);
endinterface

// ===== hw/rtl/kmer_shingle_crc32_hasher.sv =====
// A request that completes a full window is captured in the window register, and its hash is
// then registered into the response stage, which drives the response port.
// Throughput: one request per cycle unless the response side stalls; the window register
// feeds a flat XOR network of precomputed CRC columns, registered into the response stage.
// A request that does not fill the window yields no response.
// Reset (synchronous, active high) clears the fill count and the pipeline valid bits.
module kmer_shingle_crc32_hasher (
   input  logic         clock,
   input  logic         reset,
   kmsh_req_if.sink     req_chan,
   kmsh_rsp_if.source   rsp_chan
);
   import kmsh_pkg::*;

   window_type        window_ff, window_in;
   fill_type          fill_ff, fill_in;
   logic              calc_valid_ff, calc_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0] rsp_hash_ff, rsp_hash_in;
   logic [HASH_W-1:0] calc_hash;
   logic              req_fire;
   logic              calc_advance;

   kmsh_crc_window u_crc (
      .window (window_ff),
      .hash   (calc_hash)
   );

   assign calc_advance   = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !calc_valid_ff || calc_advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Bytes left over from an earlier sequence are always shifted out before the
   // window is full again, so a new sequence only needs to restart the count.
   always_comb begin
      window_in     = window_ff;
      fill_in       = fill_ff;
      calc_valid_in = calc_valid_ff && !calc_advance;
      if (req_fire) begin
         for (int i = 0; i < SHINGLE_LEN - 1; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_in[SHINGLE_LEN-1] = req_chan.seq_byte;
         if (req_chan.seq_start) begin
            fill_in = fill_type'(1);
         end else if (fill_ff < fill_type'(SHINGLE_LEN)) begin
            fill_in = fill_ff + fill_type'(1);
         end
         calc_valid_in = (fill_in == fill_type'(SHINGLE_LEN));
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (calc_advance) begin
         rsp_valid_in = calc_valid_ff;
         if (calc_valid_ff) begin
            rsp_hash_in = calc_hash;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         calc_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         calc_valid_ff <= calc_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.shingle_hash = rsp_hash_ff;

endmodule

// ===== hw/rtl/kmsh_crc_window.sv =====
module kmsh_crc_window (
   input  kmsh_pkg::window_type        window,
   output logic [kmsh_pkg::HASH_W-1:0] hash
);
   import kmsh_pkg::*;

   localparam crc_columns_type   CRC_COLUMNS = build_crc_columns();
   localparam logic [HASH_W-1:0] CRC_BASE    = build_crc_base();

   logic [WINDOW_W-1:0] window_bits;

   assign window_bits = window;

   // Every set window bit folds its precomputed column into the hash.
   always_comb begin
      hash = CRC_BASE;
      for (int k = 0; k < WINDOW_W; k++) begin
         if (window_bits[k]) begin
            hash = hash ^ CRC_COLUMNS[k];
         end
      end
   end

endmodule

// ===== tb/tb_kmer_shingle_crc32_hasher.sv =====
module tb_kmer_shingle_crc32_hasher;
   timeunit 1ns;
   timeprecision 1ps;

   import kmsh_pkg::*;

   localparam logic [31:0] POLY_REFLECTED = 32'hEDB8_8320;
   localparam int unsigned LONG_HOLD      = 400;
   localparam int unsigned RANDOM_ITEMS   = 1030;
   localparam int unsigned SETTLE_CYCLES  = 8;

   logic clock;
   logic reset;

   kmsh_req_if req_chan ();
   kmsh_rsp_if rsp_chan ();

   kmer_shingle_crc32_hasher uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   class shingle_scoreboard;
      logic [7:0]  window_q [SHINGLE_LEN];
      int unsigned fill;
      logic [31:0] hash_queue [$];
      int unsigned errors;

      function new();
         clear_window();
         errors = 0;
      endfunction

      function void clear_window();
         foreach (window_q[i]) window_q[i] = 8'h00;
         fill = 0;
      endfunction

      // Reflected CRC-32 over the window, oldest byte first.
      function logic [31:0] window_crc();
         logic [31:0] crc;
         crc = 32'hFFFF_FFFF;
         for (int i = 0; i < SHINGLE_LEN; i++) begin
            crc ^= {24'h0, window_q[i]};
            for (int b = 0; b < 8; b++) begin
               crc = crc[0] ? ((crc >> 1) ^ POLY_REFLECTED) : (crc >> 1);
            end
         end
         return ~crc;
      endfunction

      function void note_request(logic [7:0] seq_byte, logic seq_start);
         if (seq_start) clear_window();
         for (int i = 0; i < SHINGLE_LEN - 1; i++) window_q[i] = window_q[i+1];
         window_q[SHINGLE_LEN-1] = seq_byte;
         if (fill < SHINGLE_LEN) fill++;
         if (fill >= SHINGLE_LEN) hash_queue = {hash_queue, window_crc()};
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_hash(logic [31:0] shingle_hash);
         logic [31:0] want;
         if (hash_queue.size() == 0) begin
            report($sformatf("unexpected hash %08h", shingle_hash));
         end else begin
            want = hash_queue.pop_front();
            if (shingle_hash !== want) begin
               report($sformatf("shingle_hash %08h, expected %08h", shingle_hash, want));
            end
         end
      endtask

      function int unsigned pending();
         return hash_queue.size();
      endfunction
   endclass

   shingle_scoreboard sb;
   bit                hold_off_pending;
   bit                gaps_on;
   int unsigned       items_sent;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int unsigned idle_len();
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // Called at a rising edge; returns at the accepting edge, or after an idle gap.
   task automatic send_byte(logic [7:0] seq_byte, logic seq_start);
      int unsigned gap;
      req_chan.valid     <= 1'b1;
      req_chan.seq_byte  <= seq_byte;
      req_chan.seq_start <= seq_start;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(seq_byte, seq_start);
      items_sent++;
      gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_sequence(int unsigned len, bit with_start);
      for (int unsigned i = 0; i < len; i++) begin
         send_byte(8'($urandom), with_start && (i == 0));
      end
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [7:0] edge_bytes [9];
      edge_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00};
      gaps_on = 1'b0;
      // Right after reset the first bytes count as a sequence even without a start flag.
      foreach (edge_bytes[i]) send_byte(edge_bytes[i], 1'b0);
      // A start flag on every byte never fills the window.
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      // One byte short of a full window, then exactly a full window of all ones.
      for (int i = 0; i < SHINGLE_LEN - 1; i++) send_byte(8'hFF, i == 0);
      for (int i = 0; i < SHINGLE_LEN; i++) send_byte(8'hFF, i == 0);
      req_chan.valid <= 1'b0;
      wait_drained();
   endtask

   task automatic run_random();
      int unsigned pick;
      int unsigned drains;
      drains = 0;
      while (items_sent < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         pick    = $urandom_range(0, 99);
         if (pick < 70) begin
            send_sequence(SHINGLE_LEN + $urandom_range(0, 24), 1'b1);
         end else if (pick < 80) begin
            send_sequence($urandom_range(1, SHINGLE_LEN - 1), 1'b1);
         end else if (pick < 85) begin
            repeat ($urandom_range(2, 6)) send_byte(8'($urandom), 1'b1);
         end else if (pick < 95) begin
            // Continue whatever sequence is in the window.
            send_sequence($urandom_range(1, 10), 1'b0);
         end else begin
            send_sequence(SHINGLE_LEN + $urandom_range(40, 120), 1'b1);
         end
         if ($urandom_range(0, 39) == 0 || (drains == 0 && items_sent > RANDOM_ITEMS / 2)) begin
            req_chan.valid <= 1'b0;
            wait_drained();
            @(posedge clock);
            drains++;
         end
      end
   endtask

   // Response side: random stalls, calm stretches, and one long hold-off on request.
   initial begin
      int unsigned stall_left;
      bit          steady;
      stall_left     = 0;
      steady         = 1'b0;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left       = LONG_HOLD;
         end else if (stall_left == 0 && $urandom_range(0, 149) == 0) begin
            steady = !steady;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) sb.check_hash(rsp_chan.shingle_hash);
   end

   initial begin
      #1_000_000;
      $display("[kmer_shingle_crc32_hasher] ERROR");
      $finish;
   end

   initial begin
      sb                 = new();
      hold_off_pending   = 1'b0;
      gaps_on            = 1'b0;
      items_sent         = 0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.seq_byte  = 8'h00;
      req_chan.seq_start = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // Hold the response side off while a long sequence keeps coming, so the
      // block backs up and stops taking requests.
      @(posedge clock);
      hold_off_pending = 1'b1;
      gaps_on          = 1'b0;
      send_sequence(SHINGLE_LEN + 40, 1'b1);
      req_chan.valid <= 1'b0;
      wait_drained();
      @(posedge clock);

      items_sent = 0;
      run_random();
      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("[kmer_shingle_crc32_hasher] OK");
      end else begin
         $display("[kmer_shingle_crc32_hasher] ERROR");
      end
      $finish;
   end

endmodule
